/* hdl/kclp_pkg.sv */
// Package for the key click / long press detector: types, constants, decode function.
// No dependencies.
package kclp_pkg;

  localparam int unsigned DefaultTableDepth = 8;
  localparam int unsigned MaxEvents = 8;
  localparam int unsigned KeyW = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;

  localparam logic [7:0] EscByte = 8'h1B;
  localparam logic [8:0] ArrowBase = 9'h100;
  localparam logic [7:0] CtrlLetters = 8'd26;

  localparam logic [1:0] RegLongPress = 2'd0;
  localparam logic [1:0] RegLongGap = 2'd1;
  localparam logic [1:0] RegClickGap = 2'd2;

  localparam logic CmdBurst = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic EvClick = 1'b0;
  localparam logic EvLong = 1'b1;

  typedef enum logic [1:0] {
    OP_KEY = 2'b01,
    OP_TICK = 2'b10
  } op_t;

  // classified request between front and back
  typedef struct packed {
    op_t op;
    logic [KeyW-1:0] key;
    logic [2:0] mods;
  } req_t;

  typedef struct packed {
    logic kind;
    logic [KeyW-1:0] key;
    logic [2:0] mods;
    logic last;
  } evt_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_arrow(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h44);
  endfunction

  function automatic logic [KeyW-1:0] arrow_code(input logic [7:0] b);
    logic [8:0] t;
    t = ArrowBase + {1'b0, b - 8'h40};
    return {{(KeyW-9){1'b0}}, t};
  endfunction

  // returns {mods, key}
  function automatic logic [KeyW+2:0] decode_key(
    input logic [4:0] cnt,
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
    input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
    logic c, a, s;
    logic [KeyW-1:0] base;
    logic [3:0] m;
    c = 1'b0; a = 1'b0; s = 1'b0;
    base = {{(KeyW-8){1'b0}}, b0};
    m = b4[3:0];
    if (cnt == 5'd1 && b0 >= 8'd1 && b0 <= CtrlLetters) begin
      c = 1'b1;
      base = {{(KeyW-8){1'b0}}, 8'h40 + b0};
    end else if (cnt == 5'd1) begin
      s = is_upper(b0);
    end else if (cnt == 5'd2 && b0 == EscByte) begin
      a = 1'b1;
      s = is_upper(b1);
      base = {{(KeyW-8){1'b0}}, b1};
    end else if (cnt == 5'd3 && b0 == EscByte && b1 == 8'h5B && is_arrow(b2)) begin
      base = arrow_code(b2);
    end else if (cnt == 5'd6 && b0 == EscByte && b1 == 8'h5B && b2 == 8'h31 &&
                 b3 == 8'h3B && b4 >= 8'h30 && b4 <= 8'h39) begin
      s = (m == 4'd2) || (m == 4'd4) || (m == 4'd6) || (m == 4'd8);
      a = (m == 4'd3) || (m == 4'd4) || (m == 4'd7) || (m == 4'd8);
      c = (m == 4'd5) || (m == 4'd6) || (m == 4'd7) || (m == 4'd8);
      if (is_arrow(b5)) begin
        base = arrow_code(b5);
      end
    end
    base[23] = base[23] | c;
    base[22] = base[22] | a;
    base[21] = base[21] | s;
    return {c, a, s, base};
  endfunction

endpackage

/* hdl/kclp_front.sv */
// Front end: accepts input requests, decodes bursts, handles the stop on a lone ESC.
// Depends on kclp_pkg.
module kclp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   command,
  input  logic [4:0]             byte_count,
  input  logic [7:0]             byte0,
  input  logic [7:0]             byte1,
  input  logic [7:0]             byte2,
  input  logic [7:0]             byte3,
  input  logic [7:0]             byte4,
  input  logic [7:0]             byte5,
  output logic                   req_valid,
  output kclp_pkg::req_t         req,
  input  logic                   req_ready,
  output logic                   esc_valid,
  input  logic                   esc_ready
);
  import kclp_pkg::*;

  logic stopped;
  logic esc_pend;
  logic [KeyW+2:0] dec;
  logic take;
  logic lone_esc;

  assign full = esc_pend | ~req_ready;
  assign take = push & ~full;
  assign lone_esc = (command == CmdBurst) && byte_count == 5'd1 && byte0 == EscByte;
  assign dec = decode_key(byte_count, byte0, byte1, byte2, byte3, byte4, byte5);
  assign esc_valid = esc_pend;

  always_comb begin
    req_valid = 1'b0;
    req.op = OP_TICK;
    req.key = dec[KeyW-1:0];
    req.mods = dec[KeyW+2:KeyW];
    if (take && !stopped) begin
      if (command == CmdTick) begin
        req_valid = 1'b1;
      end else if (byte_count != 5'd0 && !lone_esc) begin
        req_valid = 1'b1;
        req.op = OP_KEY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
      esc_pend <= 1'b0;
    end else begin
      if (take && !stopped && lone_esc) begin
        stopped <= 1'b1;
        esc_pend <= 1'b1;
      end else if (esc_pend && esc_ready) begin
        esc_pend <= 1'b0;
      end
    end
  end
endmodule

/* hdl/kclp_fifo.sv */
// Short request queue between front end and table engine.
// Depends on kclp_pkg.
module kclp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  kclp_pkg::req_t wr_data,
  output logic           wr_ready,
  output logic           rd_valid,
  output kclp_pkg::req_t rd_data,
  input  logic           rd_en
);
  import kclp_pkg::*;

  req_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en && wr_ready) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en && wr_ready) wp <= ~wp;
      if (rd_en && rd_valid) rp <= ~rp;
      cnt <= cnt + 2'(wr_en && wr_ready) - 2'(rd_en && rd_valid);
    end
  end
endmodule

/* hdl/kclp_back.sv */
// Table engine: key lookup/insert and tick scan, one slot per cycle; the tick scan waits while an event is not taken.
// Depends on kclp_pkg.
module kclp_back #(
  parameter int unsigned TABLE_DEPTH = kclp_pkg::DefaultTableDepth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  kclp_pkg::req_t              req,
  output logic                        req_pop,
  input  logic [kclp_pkg::CfgW-1:0]   long_press_ms,
  input  logic [kclp_pkg::CfgW-1:0]   long_release_gap_ms,
  input  logic [kclp_pkg::CfgW-1:0]   click_release_gap_ms,
  output logic                        evt_valid,
  output kclp_pkg::evt_t              evt,
  input  logic                        evt_ready,
  output logic                        busy
);
  import kclp_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  logic [TimeW-1:0] now_ms;
  logic [TABLE_DEPTH-1:0] valid;
  logic [KeyW-1:0] skey [TABLE_DEPTH];
  logic [TimeW-1:0] sfirst [TABLE_DEPTH];
  logic [TimeW-1:0] slast [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] sdone;
  logic [2:0] smods [TABLE_DEPTH];

  req_t cur;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] ix;
  logic free_found;
  logic [IdxW-1:0] free_ix;
  logic [$clog2(MaxEvents+1)-1:0] nev;

  logic [TimeW-1:0] held, idle;
  logic hit_long, still_long, rel_long, rel_click;
  logic emit_long, emit_click, scan_end;

  // pending events for this slot (up to two is impossible: long or click only)
  evt_t pend;
  logic pend_v;

  assign ix = idx[IdxW-1:0];
  assign busy = state != S_IDLE;
  assign req_pop = (state == S_IDLE) && req_valid;
  assign held = now_ms - sfirst[ix];
  assign idle = now_ms - slast[ix];
  assign hit_long = !sdone[ix] && held >= {16'd0, long_press_ms};
  assign still_long = sdone[ix] || hit_long;
  assign rel_long = still_long && idle >= {16'd0, long_release_gap_ms};
  assign rel_click = !still_long && idle >= {16'd0, click_release_gap_ms}
                     && held < {16'd0, long_press_ms};
  assign emit_long = valid[ix] && hit_long;
  assign emit_click = valid[ix] && rel_click;
  assign scan_end = (idx == LastIdx);
  assign evt_valid = pend_v;
  assign evt = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      now_ms <= '0;
      valid <= '0;
      pend_v <= 1'b0;
      idx <= '0;
      nev <= '0;
      free_found <= 1'b0;
    end else begin
      if (pend_v && evt_ready && !(state == S_SCAN && (emit_long || emit_click))) begin
        pend_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            idx <= '0;
            nev <= '0;
            free_found <= 1'b0;
            if (req.op == OP_TICK) begin
              now_ms <= now_ms + TimeW'(1);
              state <= S_SCAN;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (valid[ix] && skey[ix] == cur.key) begin
            slast[ix] <= now_ms;
            smods[ix] <= cur.mods;
            state <= S_IDLE;
          end else begin
            if (!valid[ix] && !free_found) begin
              free_found <= 1'b1;
              free_ix <= ix;
            end
            if (scan_end) begin
              state <= S_IDLE;
              if (free_found || !valid[ix]) begin
                automatic logic [IdxW-1:0] f = free_found ? free_ix : ix;
                valid[f] <= 1'b1;
                skey[f] <= cur.key;
                sfirst[f] <= now_ms;
                slast[f] <= now_ms;
                sdone[f] <= 1'b0;
                smods[f] <= cur.mods;
              end
            end else begin
              idx <= idx + CntW'(1);
            end
          end
        end
        S_SCAN: begin
          if (!pend_v || evt_ready) begin
            if (valid[ix]) begin
              if (hit_long) sdone[ix] <= 1'b1;
              if (rel_long || rel_click) valid[ix] <= 1'b0;
            end
            if (emit_long || emit_click) begin
              pend_v <= 1'b1;
              pend.kind <= emit_long ? EvLong : EvClick;
              pend.key <= skey[ix];
              pend.mods <= smods[ix];
              nev <= nev + $bits(nev)'(1);
            end
            if (scan_end || ((emit_long || emit_click) &&
                             nev == $bits(nev)'(MaxEvents - 1))) begin
              state <= S_EMIT;
            end else begin
              idx <= idx + CntW'(1);
            end
            pend.last <= 1'b0;
          end
        end
        S_EMIT: begin
          // mark the final event of the tick if it is still held in pend
          if (pend_v && !(evt_ready)) begin
            pend.last <= 1'b1;
            state <= S_IDLE;
          end else if (pend_v && evt_ready) begin
            state <= S_IDLE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/kclp_out.sv */
// Output queue for events; stores the last-of-run mark given on in_last.
// Depends on kclp_pkg.
module kclp_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  kclp_pkg::evt_t in_evt,
  input  logic           in_last,
  output logic           in_ready,
  output logic           empty,
  input  logic           pop,
  output kclp_pkg::evt_t head
);
  import kclp_pkg::*;

  evt_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  evt_t w;

  always_comb begin
    w = in_evt;
    w.last = in_last;
  end

  assign in_ready = cnt != 3'd4;
  assign empty = cnt == 3'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 2'd1;
      if (pop && !empty) rp <= rp + 2'd1;
      cnt <= cnt + 3'(in_valid && in_ready) - 3'(pop && !empty);
    end
  end
endmodule

/* hdl/key_click_long_press_detector.sv */
// Key click / long press detector top level.
// A key request passes the front end and the request queue; the table engine then searches
// the slots, updating a match or filling a free slot. A tick holds the table engine for
// a scan of the slots (one slot a cycle, waiting on output stalls). The next request waits
// for the held-back event of a tick. Requests are queued two deep behind the front end.
// Reset (rst, synchronous) clears the table valid bits, the ms counter, the stop flag and
// restores the registers to 500/100/50 ms.
module key_click_long_press_detector #(
  parameter int unsigned TABLE_DEPTH = kclp_pkg::DefaultTableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [4:0]  byte_count,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  output logic        empty,
  input  logic        pop,
  output logic        event_kind,
  output logic [23:0] key_code,
  output logic        ctrl_flag,
  output logic        alt_flag,
  output logic        shift_flag,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kclp_pkg::*;

  logic [CfgW-1:0] long_press_ms, long_release_gap_ms, click_release_gap_ms;
  logic f_valid, f_ready, esc_valid, esc_ready;
  req_t f_req, q_req;
  logic q_valid, q_pop, b_req_valid;
  logic b_valid, b_ready, b_busy;
  evt_t b_evt, o_evt, head, esc_evt;
  logic o_valid, o_ready, o_last;
  logic tail_pend;
  evt_t tail_evt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= 16'd500;
      long_release_gap_ms <= 16'd100;
      click_release_gap_ms <= 16'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegLongPress: long_press_ms <= cfg_data;
        RegLongGap: long_release_gap_ms <= cfg_data;
        RegClickGap: click_release_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  kclp_front u_front (
    .clk, .rst, .push, .full, .command, .byte_count,
    .byte0, .byte1, .byte2, .byte3, .byte4, .byte5,
    .req_valid(f_valid), .req(f_req), .req_ready(f_ready),
    .esc_valid, .esc_ready
  );

  kclp_fifo u_fifo (
    .clk, .rst, .wr_en(f_valid), .wr_data(f_req), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_req), .rd_en(q_pop)
  );

  // a new request starts only once the previous tick's held event is out
  assign b_req_valid = q_valid && !tail_pend;

  kclp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .req_valid(b_req_valid), .req(q_req), .req_pop(q_pop),
    .long_press_ms, .long_release_gap_ms, .click_release_gap_ms,
    .evt_valid(b_valid), .evt(b_evt), .evt_ready(b_ready), .busy(b_busy)
  );

  // Hold one event back so the final event of a tick can be marked.
  always_comb begin
    esc_evt.kind = EvClick;
    esc_evt.key = {16'd0, EscByte};
    esc_evt.mods = 3'b000;
    esc_evt.last = 1'b1;
  end

  assign b_ready = !tail_pend || o_ready;
  assign esc_ready = !tail_pend && !b_busy && !q_valid && o_ready;

  always_comb begin
    o_valid = 1'b0;
    o_evt = tail_evt;
    o_last = 1'b0;
    if (tail_pend) begin
      o_valid = b_valid || !b_busy;
      o_last = !b_valid;
    end else if (esc_valid && esc_ready) begin
      o_valid = 1'b1;
      o_evt = esc_evt;
      o_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pend <= 1'b0;
    end else begin
      if (b_valid && b_ready) begin
        tail_pend <= 1'b1;
        tail_evt <= b_evt;
      end else if (tail_pend && o_valid && o_ready) begin
        tail_pend <= 1'b0;
      end
    end
  end

  kclp_out u_out (
    .clk, .rst, .in_valid(o_valid), .in_evt(o_evt), .in_last(o_last),
    .in_ready(o_ready), .empty, .pop, .head
  );

  assign event_kind = head.kind;
  assign key_code = head.key;
  assign ctrl_flag = head.mods[2];
  assign alt_flag = head.mods[1];
  assign shift_flag = head.mods[0];
  assign last_of_run = head.last;
endmodule
